// ===== rtl/m4i_pkg.sv =====
`default_nettype none
package m4i_pkg;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_DET_CLR,
    DP_ACC_CLR,
    DP_LOAD,
    DP_MUL,
    DP_ACC_ADD,
    DP_ACC_SUB,
    DP_COF,
    DP_DET_ADD,
    DP_DIV,
    DP_ROUND,
    DP_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       wr;
    logic [3:0] waddr;
    logic [3:0] raddr;
    logic       neg;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic det_zero;
    logic out_taken;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_COF,
    ST_FETCH,
    ST_USE,
    ST_MUL,
    ST_ACC,
    ST_COFD,
    ST_DFETCH,
    ST_DUSE,
    ST_DMUL,
    ST_DADD,
    ST_DCHK,
    ST_DIV,
    ST_DWAIT,
    ST_ROUND,
    ST_EMIT,
    ST_ZERO,
    ST_ZEMIT
  } state_t;

  localparam int unsigned TERMS = 6;

  // Column of the 3x3 minor used by factor f of Leibniz term t.
  // Terms 0..2 are even permutations, 3..5 odd.
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] f);
    logic [1:0] c;
    c = 2'd0;
    case (t)
      3'd0: c = f;
      3'd1: c = (f == 2'd0) ? 2'd1 : (f == 2'd1) ? 2'd2 : 2'd0;
      3'd2: c = (f == 2'd0) ? 2'd2 : (f == 2'd1) ? 2'd0 : 2'd1;
      3'd3: c = (f == 2'd0) ? 2'd0 : (f == 2'd1) ? 2'd2 : 2'd1;
      3'd4: c = (f == 2'd0) ? 2'd1 : (f == 2'd1) ? 2'd0 : 2'd2;
      3'd5: c = (f == 2'd0) ? 2'd2 : (f == 2'd1) ? 2'd1 : 2'd0;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Store address of factor f, term t, of the minor that drops (row, col).
  function automatic logic [3:0] elem_addr(input logic [1:0] row, input logic [1:0] col,
                                           input logic [2:0] t, input logic [1:0] f);
    logic [1:0] r;
    logic [1:0] pc;
    logic [1:0] c;
    r  = (f < row) ? f : f + 2'd1;
    pc = perm_col(t, f);
    c  = (pc < col) ? pc : pc + 2'd1;
    return {r, c};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/m4i_ctrl.sv =====
`default_nettype none
module m4i_ctrl
  import m4i_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [2:0] term_r, term_nxt;
  logic [1:0] fac_r, fac_nxt;
  logic       det_ph_r, det_ph_nxt;

  logic [1:0] row, col;
  logic       in_acc;

  assign row    = det_ph_r ? 2'd0 : idx_r[1:0];
  assign col    = det_ph_r ? idx_r[1:0] : idx_r[3:2];
  assign in_acc = in_tvalid && (state_r == ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= '0;
      idx_r    <= '0;
      term_r   <= '0;
      fac_r    <= '0;
      det_ph_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      term_r   <= term_nxt;
      fac_r    <= fac_nxt;
      det_ph_r <= det_ph_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    term_nxt   = term_r;
    fac_nxt    = fac_r;
    det_ph_nxt = det_ph_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            idx_nxt    = '0;
            det_ph_nxt = 1'b1;
            state_nxt  = ST_COF;
          end
        end
      end
      ST_COF: begin
        term_nxt  = '0;
        fac_nxt   = '0;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = ST_USE;
      ST_USE: begin
        if (fac_r == 2'd0) begin
          fac_nxt   = 2'd1;
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!status.mul_busy) begin
          if (fac_r == 2'd2) begin
            state_nxt = ST_ACC;
          end else begin
            fac_nxt   = 2'd2;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_ACC: begin
        fac_nxt = '0;
        if (term_r == 3'(TERMS - 1)) begin
          state_nxt = ST_COFD;
        end else begin
          term_nxt  = term_r + 3'd1;
          state_nxt = ST_FETCH;
        end
      end
      ST_COFD:   state_nxt = det_ph_r ? ST_DFETCH : ST_DIV;
      ST_DFETCH: state_nxt = ST_DUSE;
      ST_DUSE:   state_nxt = ST_DMUL;
      ST_DMUL:   if (!status.mul_busy) state_nxt = ST_DADD;
      ST_DADD: begin
        if (idx_r == 4'd3) begin
          state_nxt = ST_DCHK;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = ST_COF;
        end
      end
      ST_DCHK: begin
        idx_nxt    = '0;
        det_ph_nxt = 1'b0;
        state_nxt  = status.det_zero ? ST_ZERO : ST_COF;
      end
      ST_DIV:   state_nxt = ST_DWAIT;
      ST_DWAIT: if (!status.div_busy) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (status.out_taken) begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = (idx_r == 4'd15) ? ST_LOAD : ST_COF;
        end
      end
      ST_ZERO: state_nxt = ST_ZEMIT;
      ST_ZEMIT: begin
        if (status.out_taken) begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = (idx_r == 4'd15) ? ST_LOAD : ST_ZERO;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_LOAD);
    cmd       = '0;
    cmd.op    = DP_NOP;
    cmd.wr    = in_acc;
    cmd.waddr = cnt_r;
    cmd.raddr = elem_addr(row, col, term_r, fac_r);
    cmd.last  = (idx_r == 4'd15);
    case (state_r)
      ST_LOAD:   if (in_acc && cnt_r == 4'd15) cmd.op = DP_DET_CLR;
      ST_COF:    cmd.op = DP_ACC_CLR;
      ST_USE:    cmd.op = (fac_r == 2'd0) ? DP_LOAD : DP_MUL;
      ST_ACC:    cmd.op = (term_r >= 3'd3) ? DP_ACC_SUB : DP_ACC_ADD;
      ST_COFD: begin
        cmd.op  = DP_COF;
        cmd.neg = row[0] ^ col[0];
      end
      ST_DFETCH: cmd.raddr = {2'd0, idx_r[1:0]};
      ST_DUSE:   cmd.op = DP_MUL;
      ST_DADD:   cmd.op = DP_DET_ADD;
      ST_DIV:    cmd.op = DP_DIV;
      ST_ROUND:  cmd.op = DP_ROUND;
      ST_ZERO:   cmd.op = DP_ZERO;
      default:   cmd.op = DP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/m4i_datapath.sv =====
`default_nettype none
module m4i_datapath
  import m4i_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  input  wire logic [ELEM_WIDTH-1:0] in_data,
  output dp_status_t                 status,
  output logic [ELEM_WIDTH-1:0]      out_value,
  output logic                       out_sing,
  output logic                       out_sat,
  output logic                       out_last,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  localparam int unsigned W   = ELEM_WIDTH;
  localparam int unsigned WC  = 3 * W + 2;
  localparam int unsigned WP  = 4 * W + 3;
  localparam int unsigned NB  = WC + 2 * FRAC_BITS;
  localparam int unsigned MCW = $clog2(W);
  localparam int unsigned DCW = $clog2(NB + 1);

  logic [W-1:0]   mem [16];
  logic [W-1:0]   rdata_r;

  logic [WP-1:0]  prod_r, mcand_r, acc_r, det_r, dmag_r;
  logic [W-1:0]   mplier_r;
  logic [MCW-1:0] mul_cnt_r;
  logic           mul_busy_r;

  logic [WP:0]    rem_r;
  logic [NB-1:0]  nq_r;
  logic [DCW-1:0] div_cnt_r;
  logic           div_busy_r, neg_r;

  logic [W-1:0]   val_r;
  logic           sing_r, sat_r, last_r, vld_r;

  logic [WP-1:0]  pmag;
  logic [WP:0]    trial;
  logic           ge;
  logic           rnd;
  logic [NB:0]    q1, lim, qv;
  logic           sat;
  logic [W-1:0]   mag, val;

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[cmd.waddr] <= in_data;
    rdata_r <= mem[cmd.raddr];
  end

  assign pmag  = prod_r[WP-1] ? -prod_r : prod_r;
  assign trial = {rem_r[WP-1:0], nq_r[NB-1]};
  assign ge    = trial >= {1'b0, dmag_r};
  assign rnd   = {rem_r, 1'b0} >= {2'b00, dmag_r};
  assign q1    = {1'b0, nq_r} + (NB+1)'(rnd);
  assign lim   = ((NB+1)'(1) << (W - 1)) - (NB+1)'(!neg_r);
  assign sat   = q1 > lim;
  assign qv    = sat ? lim : q1;
  assign mag   = qv[W-1:0];
  assign val   = neg_r ? -mag : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      div_busy_r <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      if (mul_busy_r) begin
        // the top multiplier bit weighs negative
        if (mplier_r[0]) prod_r <= (mul_cnt_r == '0) ? prod_r - mcand_r : prod_r + mcand_r;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        if (mul_cnt_r == '0) mul_busy_r <= 1'b0;
        else mul_cnt_r <= mul_cnt_r - MCW'(1);
      end
      if (div_busy_r) begin
        rem_r <= ge ? trial - {1'b0, dmag_r} : trial;
        nq_r  <= {nq_r[NB-2:0], ge};
        if (div_cnt_r == '0) div_busy_r <= 1'b0;
        else div_cnt_r <= div_cnt_r - DCW'(1);
      end
      if (vld_r && out_ready) vld_r <= 1'b0;
      case (cmd.op)
        DP_DET_CLR: det_r <= '0;
        DP_ACC_CLR: acc_r <= '0;
        DP_LOAD:    prod_r <= WP'($signed(rdata_r));
        DP_MUL: begin
          mcand_r    <= prod_r;
          mplier_r   <= rdata_r;
          prod_r     <= '0;
          mul_cnt_r  <= MCW'(W - 1);
          mul_busy_r <= 1'b1;
        end
        DP_ACC_ADD: acc_r <= acc_r + prod_r;
        DP_ACC_SUB: acc_r <= acc_r - prod_r;
        DP_COF:     prod_r <= cmd.neg ? -acc_r : acc_r;
        DP_DET_ADD: det_r <= det_r + prod_r;
        DP_DIV: begin
          dmag_r     <= det_r[WP-1] ? -det_r : det_r;
          nq_r       <= {pmag[WC-1:0], {(2 * FRAC_BITS){1'b0}}};
          rem_r      <= '0;
          neg_r      <= prod_r[WP-1] ^ det_r[WP-1];
          div_cnt_r  <= DCW'(NB - 1);
          div_busy_r <= 1'b1;
        end
        DP_ROUND: begin
          val_r  <= val;
          sing_r <= 1'b0;
          sat_r  <= sat;
          last_r <= cmd.last;
          vld_r  <= 1'b1;
        end
        DP_ZERO: begin
          val_r  <= '0;
          sing_r <= 1'b1;
          sat_r  <= 1'b0;
          last_r <= cmd.last;
          vld_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status.mul_busy  = mul_busy_r;
  assign status.div_busy  = div_busy_r;
  assign status.det_zero  = (det_r == '0);
  assign status.out_taken = vld_r && out_ready;

  assign out_value = val_r;
  assign out_sing  = sing_r;
  assign out_sat   = sat_r;
  assign out_last  = last_r;
  assign out_valid = vld_r;

endmodule
`default_nettype wire

// ===== rtl/matrix4_inverse.sv =====
// 4x4 matrix inverse by adjugate, one element per beat in and out, row-major.
// Loading accepts one element per beat. Each cofactor is computed on the bit-serial
// multiplier; the determinant follows after the last beat.
// Each result then takes a fresh cofactor plus a division, rounding and emit step,
// or only the emit step when singular, and waits while out_tready is low.
// Synchronous active-low reset returns to loading with the element count at zero.
`default_nettype none
module matrix4_inverse
  import m4i_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [((ELEM_WIDTH+7)/8)*8-1:0]    in_tdata,   // element_value
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [((ELEM_WIDTH+7)/8)*8-1:0]         out_tdata,  // inverse_value
  output logic [1:0]                              out_tuser,  // saturated, singular
  output logic                                    out_tlast   // last_element
);

  localparam int unsigned DW = ((ELEM_WIDTH + 7) / 8) * 8;

  dp_cmd_t                cmd;
  dp_status_t             status;
  logic [ELEM_WIDTH-1:0]  value;
  logic                   sing, sat;

  m4i_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  m4i_datapath #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_tdata[ELEM_WIDTH-1:0]),
    .status    (status),
    .out_value (value),
    .out_sing  (sing),
    .out_sat   (sat),
    .out_last  (out_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = DW'(value);
  assign out_tuser = {sat, sing};

endmodule
`default_nettype wire
